### rtl/sva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack VM integer ALU package
// Operation codes, the classified work item and the divider pipeline record.
// ----------------------------------------------------------------------------
package sva_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned KindW    = 5;
  localparam int unsigned DivSteps = 32;

  typedef enum logic [KindW-1:0] {
    OP_ADD    = 5'd0,
    OP_SUB    = 5'd1,
    OP_MUL    = 5'd2,
    OP_DIV    = 5'd3,
    OP_MOD    = 5'd4,
    OP_AND    = 5'd5,
    OP_OR     = 5'd6,
    OP_XOR    = 5'd7,
    OP_SHL    = 5'd8,
    OP_SHR    = 5'd9,
    OP_EQ     = 5'd10,
    OP_NE     = 5'd11,
    OP_LT     = 5'd12,
    OP_LE     = 5'd13,
    OP_GT     = 5'd14,
    OP_GE     = 5'd15,
    OP_INVERT = 5'd16,
    OP_NEGATE = 5'd17,
    OP_LOGNOT = 5'd18,
    OP_TEST   = 5'd19
  } kind_e;

  // Item as classified by the front end.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] am;
    logic [DataW-1:0] bm;
    logic             neg_q;
    logic             neg_r;
    logic             dz;
  } item_t;

  // One stage of the execute pipeline.
  typedef struct packed {
    logic [2*DataW-1:0] rq;
    logic [DataW-1:0]   dvsr;
    logic [DataW-1:0]   res;
    logic               is_div;
    logic               is_mod;
    logic               neg_q;
    logic               neg_r;
    logic               dz;
  } stage_t;

  // Final result record.
  typedef struct packed {
    logic [DataW-1:0] value;
    logic             status;
  } result_t;

endpackage

### rtl/sva_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small synchronous queue
// Register-based ring buffer with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module sva_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  T              mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Storage is written only on a push transfer.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/sva_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack VM ALU front end
// Takes input items, classifies them and prepares divider operands.
// ----------------------------------------------------------------------------
module sva_front import sva_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [KindW-1:0] kind_i,
  input  logic [DataW-1:0] first_operand_i,
  input  logic [DataW-1:0] second_operand_i,
  output logic             q_push_o,
  output item_t            q_data_o,
  input  logic             q_full_i
);

  logic  vld_q;
  item_t item_q, item_d;
  logic  an, bn, take;

  // Classification: signs, magnitudes and the zero divisor flag.
  always_comb begin
    an            = first_operand_i[DataW-1];
    bn            = second_operand_i[DataW-1];
    item_d.kind   = kind_i;
    item_d.a      = first_operand_i;
    item_d.b      = second_operand_i;
    item_d.am     = an ? (DataW'(0) - first_operand_i) : first_operand_i;
    item_d.bm     = bn ? (DataW'(0) - second_operand_i) : second_operand_i;
    item_d.neg_q  = an ^ bn;
    item_d.neg_r  = an;
    item_d.dz     = (second_operand_i == '0);
  end

  // The holding register frees up whenever the queue takes its item.
  assign q_push_o = vld_q;
  assign q_data_o = item_q;
  assign full     = vld_q && q_full_i;
  assign take     = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (!q_full_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

### rtl/sva_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack VM ALU back end
// Execute pipeline: simple operations and multiply at entry, then a
// one-bit-per-stage restoring divider, then sign fix-up.
// ----------------------------------------------------------------------------
module sva_back import sva_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   in_data_i,
  input  logic    in_empty_i,
  output logic    in_pop_o,
  output logic    out_push_o,
  output result_t out_data_o,
  input  logic    out_full_i
);

  logic   [DivSteps:0] vld_q;
  stage_t              stg_q [DivSteps+1];
  stage_t              entry_d;
  logic                adv;
  logic [DataW-1:0]    a, b, q, r;
  logic [DataW-1:0]    sra;
  logic [4:0]          sh;
  logic                big;

  // One restoring division step.
  function automatic stage_t div_step(stage_t s);
    stage_t      o;
    logic [DataW:0] trial;
    begin
      o     = s;
      trial = s.rq[2*DataW-1:DataW-1] - {1'b0, s.dvsr};
      if (!trial[DataW]) begin
        o.rq = {trial[DataW-1:0], s.rq[DataW-2:0], 1'b1};
      end else begin
        o.rq = {s.rq[2*DataW-2:0], 1'b0};
      end
      return o;
    end
  endfunction

  // Entry stage: everything except division finishes here.
  always_comb begin
    a   = in_data_i.a;
    b   = in_data_i.b;
    sh  = b[4:0];
    big = (b[DataW-1:5] != '0);
    // Arithmetic right shift kept in its own signed expression.
    sra = $signed(a) >>> sh;
    entry_d.rq     = {{DataW{1'b0}}, in_data_i.am};
    entry_d.dvsr   = in_data_i.bm;
    entry_d.is_div = (in_data_i.kind == OP_DIV) || (in_data_i.kind == OP_MOD);
    entry_d.is_mod = (in_data_i.kind == OP_MOD);
    entry_d.neg_q  = in_data_i.neg_q;
    entry_d.neg_r  = in_data_i.neg_r;
    entry_d.dz     = in_data_i.dz;
    case (in_data_i.kind)
      OP_ADD:    entry_d.res = a + b;
      OP_SUB:    entry_d.res = a - b;
      OP_MUL:    entry_d.res = a * b;
      OP_AND:    entry_d.res = a & b;
      OP_OR:     entry_d.res = a | b;
      OP_XOR:    entry_d.res = a ^ b;
      OP_SHL:    entry_d.res = big ? '0 : (a << sh);
      OP_SHR:    entry_d.res = big ? {DataW{a[DataW-1]}} : sra;
      OP_EQ:     entry_d.res = DataW'(a == b);
      OP_NE:     entry_d.res = DataW'(a != b);
      OP_LT:     entry_d.res = DataW'($signed(a) < $signed(b));
      OP_LE:     entry_d.res = DataW'($signed(a) <= $signed(b));
      OP_GT:     entry_d.res = DataW'($signed(a) > $signed(b));
      OP_GE:     entry_d.res = DataW'($signed(a) >= $signed(b));
      OP_INVERT: entry_d.res = ~b;
      OP_NEGATE: entry_d.res = DataW'(0) - b;
      OP_LOGNOT: entry_d.res = DataW'(b == '0);
      OP_TEST:   entry_d.res = DataW'(b != '0);
      default:   entry_d.res = '0;
    endcase
  end

  // The whole pipeline holds only when the last stage cannot leave.
  assign adv        = !(vld_q[DivSteps] && out_full_i);
  assign in_pop_o   = adv && !in_empty_i;
  assign out_push_o = vld_q[DivSteps] && !out_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DivSteps-1:0], !in_empty_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      stg_q[0] <= entry_d;
    end
  end

  // Divider stages, one quotient bit each.
  for (genvar k = 1; k <= DivSteps; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv) begin
        stg_q[k] <= div_step(stg_q[k-1]);
      end
    end
  end

  // Sign fix-up and final selection.
  always_comb begin
    q = stg_q[DivSteps].rq[DataW-1:0];
    r = stg_q[DivSteps].rq[2*DataW-1:DataW];
    out_data_o.status = stg_q[DivSteps].is_div && stg_q[DivSteps].dz;
    if (!stg_q[DivSteps].is_div) begin
      out_data_o.value = stg_q[DivSteps].res;
    end else if (stg_q[DivSteps].dz) begin
      out_data_o.value = '0;
    end else if (stg_q[DivSteps].is_mod) begin
      out_data_o.value = stg_q[DivSteps].neg_r ? (DataW'(0) - r) : r;
    end else begin
      out_data_o.value = stg_q[DivSteps].neg_q ? (DataW'(0) - q) : q;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_full_i) else $error("push into full result queue");
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[DivSteps] && out_full_i) |=> vld_q[DivSteps])
    else $error("stalled result lost");
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push_o && out_data_o.status) |-> (out_data_o.value == '0))
    else $error("divide by zero with nonzero value");
`endif

endmodule

### rtl/stack_vm_integer_alu_top.sv
`timescale 1ns / 1ps
// From input transfer to result: front register, item queue, entry stage,
// 32 divider stages and result queue; the front register loads at the
// transfer edge itself. The divider is fully pipelined.
// Throughput: one item per cycle unless the result queue is full.
// Reset: asynchronous, active low; clears all queues and valid bits.
// ----------------------------------------------------------------------------
// Stack VM integer ALU top level
// Front end, decoupling queue, execute pipeline and result queue.
// ----------------------------------------------------------------------------
module stack_vm_integer_alu_top import sva_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [KindW-1:0] kind_i,
  input  logic [DataW-1:0] first_operand_i,
  input  logic [DataW-1:0] second_operand_i,
  output logic             empty,
  input  logic             pop,
  output logic [DataW-1:0] result_value_o,
  output logic             status_o
);

  item_t   fq_in, fq_out;
  logic    fq_push, fq_full, fq_pop, fq_empty;
  result_t rq_in, rq_out;
  logic    rq_push, rq_full;

  sva_front u_front (
    .clk_i, .rst_ni, .push, .full, .kind_i, .first_operand_i, .second_operand_i,
    .q_push_o(fq_push), .q_data_o(fq_in), .q_full_i(fq_full)
  );

  sva_fifo #(.T(item_t), .DEPTH(QUEUE_DEPTH)) u_item_q (
    .clk_i, .rst_ni, .push_i(fq_push), .data_i(fq_in), .full_o(fq_full),
    .pop_i(fq_pop), .data_o(fq_out), .empty_o(fq_empty)
  );

  sva_back u_back (
    .clk_i, .rst_ni, .in_data_i(fq_out), .in_empty_i(fq_empty), .in_pop_o(fq_pop),
    .out_push_o(rq_push), .out_data_o(rq_in), .out_full_i(rq_full)
  );

  sva_fifo #(.T(result_t), .DEPTH(QUEUE_DEPTH)) u_result_q (
    .clk_i, .rst_ni, .push_i(rq_push), .data_i(rq_in), .full_o(rq_full),
    .pop_i(pop), .data_o(rq_out), .empty_o(empty)
  );

  assign result_value_o = rq_out.value;
  assign status_o       = rq_out.status;

endmodule

### tb/stack_vm_integer_alu_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack VM integer ALU testbench
// Drives directed and random operations through the push side, predicts each
// result with a behavioral ALU model and compares the popped results in order.
// ----------------------------------------------------------------------------
module stack_vm_integer_alu_top_tb;
  import sva_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 60;

  typedef struct {
    logic [KindW-1:0] kind;
    logic [DataW-1:0] lhs;
    logic [DataW-1:0] rhs;
    bit               hold;
  } alu_op_t;

  typedef struct {
    logic [DataW-1:0] value;
    logic             status;
  } alu_res_t;

  logic             clk;
  logic             rst_n;
  logic             push;
  logic             full;
  logic [KindW-1:0] kind;
  logic [DataW-1:0] first_operand;
  logic [DataW-1:0] second_operand;
  logic             empty;
  logic             pop;
  logic [DataW-1:0] result_value;
  logic             status;

  alu_op_t  op_queue[$];
  alu_res_t expected_results[$];
  int       error_count;
  int       idle_cycles;
  bit       stimulus_done;
  int       send_wait;
  int       pop_wait;
  bit       hold_active;
  logic     full_seen;
  logic     empty_seen;

  stack_vm_integer_alu_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .push            (push),
    .full            (full),
    .kind_i          (kind),
    .first_operand_i (first_operand),
    .second_operand_i(second_operand),
    .empty           (empty),
    .pop             (pop),
    .result_value_o  (result_value),
    .status_o        (status)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Computes the expected value and status of one ALU operation.
  function automatic alu_res_t alu_compute(logic [KindW-1:0] op, logic [DataW-1:0] a,
                                           logic [DataW-1:0] b);
    alu_res_t                res;
    logic [DataW-1:0]        mag_a;
    logic [DataW-1:0]        mag_b;
    logic [DataW-1:0]        quo;
    logic [DataW-1:0]        rem;
    logic signed [DataW-1:0] sra;
    res.value  = '0;
    res.status = 1'b0;
    mag_a = a[31] ? -a : a;
    mag_b = b[31] ? -b : b;
    quo = (b != 0) ? mag_a / mag_b : '0;
    rem = (b != 0) ? mag_a % mag_b : '0;
    sra = $signed(a) >>> b[4:0];
    case (op)
      OP_ADD: res.value = a + b;
      OP_SUB: res.value = a - b;
      OP_MUL: res.value = a * b;
      OP_DIV, OP_MOD: begin
        if (b == 0) begin
          res.status = 1'b1;
        end else if (op == OP_DIV) begin
          res.value = (a[31] != b[31]) ? -quo : quo;
        end else begin
          res.value = a[31] ? -rem : rem;
        end
      end
      OP_AND: res.value = a & b;
      OP_OR:  res.value = a | b;
      OP_XOR: res.value = a ^ b;
      OP_SHL: res.value = (b >= 32) ? '0 : a << b[4:0];
      OP_SHR: res.value = (b >= 32) ? {DataW{a[31]}} : sra;
      OP_EQ:  res.value = DataW'(a == b);
      OP_NE:  res.value = DataW'(a != b);
      OP_LT:  res.value = DataW'($signed(a) < $signed(b));
      OP_LE:  res.value = DataW'($signed(a) <= $signed(b));
      OP_GT:  res.value = DataW'($signed(a) > $signed(b));
      OP_GE:  res.value = DataW'($signed(a) >= $signed(b));
      OP_INVERT: res.value = ~b;
      OP_NEGATE: res.value = -b;
      OP_LOGNOT: res.value = DataW'(b == 0);
      OP_TEST:   res.value = DataW'(b != 0);
      default:   res.value = '0;
    endcase
    return res;
  endfunction

  function automatic logic [DataW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      4, 5: return DataW'($urandom_range(0, 40)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(logic [KindW-1:0] op, logic [DataW-1:0] a, logic [DataW-1:0] b,
                        bit hold = 1'b0);
    alu_op_t item;
    item.kind = op;
    item.lhs  = a;
    item.rhs  = b;
    item.hold = hold;
    op_queue.push_back(item);
  endtask

  // Stimulus: directed corner cases, then random operations.
  initial begin
    kind_e k;
    push = 1'b0;
    pop = 1'b0;
    kind = '0;
    first_operand = '0;
    second_operand = '0;
    stimulus_done = 1'b0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_op(OP_DIV, 32'd7, 32'd0);
    add_op(OP_MOD, 32'h8000_0000, 32'd0);
    add_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    add_op(OP_MOD, 32'h8000_0000, 32'hffff_ffff);
    add_op(OP_MOD, -32'sd7, 32'd2);
    add_op(OP_MOD, 32'd7, -32'sd2);
    add_op(OP_DIV, -32'sd7, 32'd2);
    add_op(OP_ADD, 32'h7fff_ffff, 32'd1);
    add_op(OP_MUL, 32'h8000_0000, 32'hffff_ffff);
    add_op(OP_SHL, 32'hffff_ffff, 32'd32);
    add_op(OP_SHL, 32'd1, 32'd31);
    add_op(OP_SHR, 32'h8000_0000, 32'hffff_ffff);
    add_op(OP_SHR, 32'h7fff_ffff, 32'd40);
    add_op(OP_SHR, 32'h8000_0000, 32'd31);
    add_op(OP_LT, 32'h8000_0000, 32'h7fff_ffff);
    add_op(OP_GE, 32'h7fff_ffff, 32'h8000_0000);
    add_op(OP_EQ, 32'h1234_5678, 32'h1234_5678, 1'b1);
    add_op(OP_NEGATE, 32'd5, 32'h8000_0000);
    add_op(OP_LOGNOT, 32'd9, 32'd0);
    add_op(OP_TEST, 32'd0, 32'hffff_ffff);
    add_op(5'd20, 32'd1, 32'd1);
    add_op(5'd31, 32'hffff_ffff, 32'hffff_ffff);
    // Every kind once with full-width operands.
    for (int i = 0; i < 20; i++) begin
      k = kind_e'(i);
      add_op(k, 32'hffff_ffff, 32'hffff_ffff);
    end

    // Random part: mostly defined operations, with extreme and small operands.
    for (int n = 0; n < 1100; n++) begin
      add_op($urandom_range(0, 15) == 0 ? KindW'($urandom_range(20, 31))
                                        : KindW'($urandom_range(0, 19)),
             pick_operand(), pick_operand(), n == 550);
    end
    stimulus_done = 1'b1;
  end

  // Tracks whether the current push completed at the rising edge.
  always @(posedge clk) begin
    full_seen <= full;
  end

  // Driver: presents queued operations at the falling edge with random gaps.
  always @(negedge clk) begin
    alu_op_t item;
    if (rst_n) begin
      if (!push || !full_seen) begin
        if (send_wait > 0) begin
          send_wait <= send_wait - 1;
          push <= 1'b0;
        end else if (hold_active) begin
          push <= 1'b0;
          if (expected_results.size() == 0) begin
            hold_active <= 1'b0;
          end
        end else if (op_queue.size() > 0) begin
          item = op_queue.pop_front();
          push <= 1'b1;
          kind <= item.kind;
          first_operand <= item.lhs;
          second_operand <= item.rhs;
          send_wait <= $urandom_range(0, 3);
          hold_active <= item.hold;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: after each result waits a random number of cycles before popping again.
  always @(negedge clk) begin
    int w;
    if (rst_n) begin
      if (pop && !empty_seen) begin
        w = $urandom_range(0, 3);
        if (w == 0) begin
          pop <= 1'b1;
        end else begin
          pop <= 1'b0;
          pop_wait <= w - 1;
        end
      end else if (pop_wait > 0) begin
        pop_wait <= pop_wait - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    empty_seen <= empty;
  end

  // Monitor: predicts on input transfers and checks output transfers.
  always @(posedge clk) begin
    alu_res_t want;
    bit       moved;
    int       errs;
    moved = 1'b0;
    errs  = 0;
    if (rst_n) begin
      if (pop && !empty) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          $error("unexpected result: result_value %h status %b", result_value, status);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (result_value !== want.value) begin
            $error("result_value mismatch: expected %h, actual %h", want.value, result_value);
            errs++;
          end
          if (status !== want.status) begin
            $error("status mismatch: expected %b, actual %b", want.status, status);
            errs++;
          end
        end
      end
      if (push && !full) begin
        expected_results.push_back(alu_compute(kind, first_operand, second_operand));
        moved = 1'b1;
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      error_count <= error_count + errs;
    end
  end

  // End of run and watchdog.
  initial begin
    error_count = 0;
    idle_cycles = 0;
    send_wait = 0;
    pop_wait = 0;
    hold_active = 1'b0;
    full_seen = 1'b0;
    empty_seen = 1'b1;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (idle_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
      if (stimulus_done && op_queue.size() == 0 && !push && expected_results.size() == 0)
        break;
    end
    repeat (DrainCycles) @(posedge clk);
    #1;
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
